// ===== rtl/kdlp_pkg.sv =====
// Shared constants, codes and types for the key debouncer with long-press detection.
package kdlp_pkg;

    localparam int NUM_KEYS_DEF = 22;
    localparam int LEVEL_BITS   = 22;
    localparam int IDX_W        = 5;
    localparam int COUNT_W      = 8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 72;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [COUNT_W-1:0] PRESS_TICKS_RST   = 8'd10;
    localparam logic [COUNT_W-1:0] LONG_TICKS_RST    = 8'd100;
    localparam logic [COUNT_W-1:0] RELEASE_TICKS_RST = 8'd10;

    typedef enum logic [1:0] {
        REG_PRESS_TICKS   = 2'd0,
        REG_LONG_TICKS    = 2'd1,
        REG_RELEASE_TICKS = 2'd2
    } kdlp_reg_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } kdlp_press_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } kdlp_op_t;

    typedef struct packed {
        logic [COUNT_W-1:0] press_ticks;
        logic [COUNT_W-1:0] long_ticks;
        logic [COUNT_W-1:0] release_ticks;
    } kdlp_cfg_t;

    typedef struct packed {
        logic pressed;
        logic is_long;
        logic released;
    } kdlp_event_t;

endpackage

// ===== rtl/kdlp_cfg.sv =====
// Threshold registers behind the APB configuration port.
module kdlp_cfg
    import kdlp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output kdlp_cfg_t             cfg_o
);

    kdlp_cfg_t cfg_reg;
    kdlp_cfg_t cfg_next;
    kdlp_reg_t reg_sel;
    logic      wr_en;

    assign pready  = 1'b1;
    assign reg_sel = kdlp_reg_t'(paddr[3:2]);
    assign wr_en   = psel & penable & pwrite & pready;
    assign cfg_o   = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_sel)
                REG_PRESS_TICKS:   cfg_next.press_ticks   = pwdata[COUNT_W-1:0];
                REG_LONG_TICKS:    cfg_next.long_ticks    = pwdata[COUNT_W-1:0];
                REG_RELEASE_TICKS: cfg_next.release_ticks = pwdata[COUNT_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_PRESS_TICKS:   prdata = CFG_DATA_W'(cfg_reg.press_ticks);
            REG_LONG_TICKS:    prdata = CFG_DATA_W'(cfg_reg.long_ticks);
            REG_RELEASE_TICKS: prdata = CFG_DATA_W'(cfg_reg.release_ticks);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.press_ticks   <= PRESS_TICKS_RST;
            cfg_reg.long_ticks    <= LONG_TICKS_RST;
            cfg_reg.release_ticks <= RELEASE_TICKS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/kdlp_lane.sv =====
// One key's debounce counters and latched press and release events.
module kdlp_lane
    import kdlp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  logic        clear,
    input  logic        level_released,
    input  kdlp_cfg_t   cfg_i,
    output kdlp_event_t ev_o
);

    logic [COUNT_W-1:0] held_reg, held_next;
    logic [COUNT_W-1:0] free_reg, free_next;
    kdlp_press_t        press_reg, press_next;
    logic               rel_reg, rel_next;
    logic [COUNT_W-1:0] held_inc;
    logic [COUNT_W-1:0] free_inc;

    assign held_inc = (held_reg == COUNT_MAX) ? held_reg : held_reg + 1'b1;
    assign free_inc = (free_reg == COUNT_MAX) ? free_reg : free_reg + 1'b1;

    always_comb begin
        held_next  = held_reg;
        free_next  = free_reg;
        press_next = press_reg;
        rel_next   = rel_reg;
        if (advance) begin
            if (level_released) begin
                held_next = '0;
                free_next = free_inc;
                if ((free_inc > cfg_i.release_ticks) && (press_reg != EV_NONE)) begin
                    rel_next = 1'b1;
                end
            end else begin
                free_next = '0;
                held_next = held_inc;
                // The long test comes first and wins even below the short threshold.
                if (held_inc > cfg_i.long_ticks) begin
                    press_next = EV_LONG;
                end else if (held_inc > cfg_i.press_ticks) begin
                    press_next = EV_SHORT;
                end
            end
        end else if (clear) begin
            press_next = EV_NONE;
            rel_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= '0;
            free_reg  <= '0;
            press_reg <= EV_NONE;
            rel_reg   <= 1'b0;
        end else begin
            held_reg  <= held_next;
            free_reg  <= free_next;
            press_reg <= press_next;
            rel_reg   <= rel_next;
        end
    end

    assign ev_o.pressed  = (press_next != EV_NONE);
    assign ev_o.is_long  = (press_next == EV_LONG);
    assign ev_o.released = rel_next;

endmodule

// ===== rtl/kdlp_merge.sv =====
// Packs the lanes' events into flag words and holds them in a two-entry output buffer.
module kdlp_merge
    import kdlp_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  kdlp_event_t          ev_i [NUM_KEYS],
    output logic                 ready_o,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [LEVEL_BITS-1:0]   pf, lf, rf;
    logic [3*LEVEL_BITS-1:0] word;
    logic [3*LEVEL_BITS-1:0] out_reg, out_next;
    logic [3*LEVEL_BITS-1:0] skid_reg, skid_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    skid_valid_reg, skid_valid_next;
    logic                    pop;

    for (genvar k = 0; k < LEVEL_BITS; k++) begin : g_flag
        if (k < NUM_KEYS) begin : g_key
            assign pf[k] = ev_i[k].pressed;
            assign lf[k] = ev_i[k].is_long;
            assign rf[k] = ev_i[k].released;
        end else begin : g_none
            assign pf[k] = 1'b0;
            assign lf[k] = 1'b0;
            assign rf[k] = 1'b0;
        end
    end

    assign word = {rf, lf, pf};
    assign pop  = out_valid_reg & m_tready;

    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = word;
                out_valid_next = push;
            end
        end else if (push) begin
            // The output is stalled, so the new result parks in the skid entry.
            skid_next       = word;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign ready_o  = ~skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - 3*LEVEL_BITS)'(0), out_reg};

endmodule

// ===== rtl/key_debounce_long_press_top.sv =====
// Key debouncer with short/long press and release detection, top level.
// Every accepted tick transaction updates all keys, one lane per key with its own 8-bit held
// and free counters; a clear clears only the key at clear_index. One transaction is taken
// every clock cycle while s_tready is high, and its flag result is registered in a two-entry
// output buffer; s_tready drops only when both entries are full. The thresholds press_ticks,
// long_ticks and release_ticks sit at APB byte addresses 0x0, 0x4 and 0x8, reset to 10, 100
// and 10, and should be written only while no transaction is in flight.
module key_debounce_long_press_top
    import kdlp_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [21:0] key_levels, [26:22] clear_index, [31:27] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [0] operation
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [21:0] pressed_flags, [43:22] long_flags, [65:44] released_flags, [71:66] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    kdlp_cfg_t             cfg;
    kdlp_event_t           ev [NUM_KEYS];
    logic                  accept;
    logic                  do_sample;
    logic                  do_clear;
    logic [LEVEL_BITS-1:0] key_levels;
    logic [IDX_W-1:0]      clear_index;

    assign key_levels  = s_tdata[LEVEL_BITS-1:0];
    assign clear_index = s_tdata[LEVEL_BITS +: IDX_W];
    assign accept      = s_tvalid & s_tready;
    assign do_sample   = accept & (kdlp_op_t'(s_tuser[0]) == OP_SAMPLE);
    assign do_clear    = accept & (kdlp_op_t'(s_tuser[0]) == OP_CLEAR);

    kdlp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg_o   (cfg)
    );

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        logic released;
        logic hit;

        // Keys without an input bit read as pressed.
        if (k < LEVEL_BITS) begin : g_lvl
            assign released = key_levels[k];
        end else begin : g_nolvl
            assign released = 1'b0;
        end

        if (k < (1 << IDX_W)) begin : g_idx
            assign hit = (clear_index == IDX_W'(k));
        end else begin : g_noidx
            assign hit = 1'b0;
        end

        kdlp_lane u_lane (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .advance        (do_sample),
            .clear          (do_clear & hit),
            .level_released (released),
            .cfg_i          (cfg),
            .ev_o           (ev[k])
        );
    end

    kdlp_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (accept),
        .ev_i     (ev),
        .ready_o  (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/kdlp_checker.sv =====
// Port-level assertions for the key debouncer, bound to the top level.
module kdlp_checker
    import kdlp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // Reset empties the output buffer.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result stays in place.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A long press is always also a press.
    a_long_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[2*LEVEL_BITS-1:LEVEL_BITS] & ~m_tdata[LEVEL_BITS-1:0]) == '0))
        else $error("long flag without press flag");

    // A transaction taken with the buffer empty shows its result in the next cycle.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> m_tvalid)
        else $error("result missing after accepted transaction");

endmodule

bind key_debounce_long_press_top kdlp_checker u_kdlp_checker (.*);
